FILE: hdl/sfr_pkg.sv
// Shared types and constants of the serial frame receiver.
package sfr_pkg;

	// Fixed frame overhead: head, address, length, checksum and tail.
	localparam int OVERHEAD_BYTES = 5;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_HEAD_BYTE        = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TAIL_BYTE        = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_STATION_ADDRESS  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_RELOAD   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_FRAME_LENGTH = 3'd4;

	localparam logic [15:0] TIMEOUT_RELOAD_RESET   = 16'd100;
	localparam logic [6:0]  MAX_FRAME_LENGTH_RESET = 7'd50;

	typedef enum logic [1:0] {
		CMD_BYTE    = 2'd0,
		CMD_TICK    = 2'd1,
		CMD_READ    = 2'd2,
		CMD_RELEASE = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [7:0]  head_byte;
		logic [7:0]  tail_byte;
		logic [7:0]  station_address;
		logic [15:0] timeout_reload;
		logic [6:0]  max_frame_length;
	} cfg_t;

	typedef struct packed {
		logic       frame_ready;
		logic [6:0] payload_count;
		logic       byte_ignored;
	} result_t;

endpackage

FILE: hdl/serial_frame_receiver.sv
// Top level of the serial frame receiver: request pipeline, config, parser and payload store.
//
//   channel  direction  handshake                  payload
//   in       sink       in_valid / in_stall        command, rx_byte, read_index
//   out      source     out_valid / out_stall      frame_ready, payload_count,
//                                                  read_byte, byte_ignored
//   cfg      sink       cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Each request passes through the input register and then the result register, one request
// per cycle sustained while out_stall is low. This depth is set by the registered read of
// the payload RAM, which is addressed from the input register.
// Reset clears all control state; the payload store is not cleared.
// A stall on the result side holds the result register and the input register in turn.
module serial_frame_receiver #(
	parameter int PAYLOAD_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        command,
	input  logic [7:0]                        rx_byte,
	input  logic [5:0]                        read_index,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              frame_ready,
	output logic [6:0]                        payload_count,
	output logic [7:0]                        read_byte,
	output logic                              byte_ignored,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sfr_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int AW = $clog2(PAYLOAD_DEPTH);

	sfr_pkg::cfg_t    cfg;
	sfr_pkg::result_t res;
	sfr_pkg::result_t res_s2;
	sfr_pkg::cmd_t    cmd_s1;
	logic             v_s1, v_s2;
	logic [7:0]       byte_s1;
	logic [5:0]       ridx_s1;
	logic             rd_ok_s2;
	logic             adv;
	logic             in_take;
	logic [8:0]       ridx_wide;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [7:0]       ram_wdata;
	logic [7:0]       ram_rdata;

	assign adv       = v_s1 && (!v_s2 || !out_stall);
	assign in_stall  = v_s1 && !adv;
	assign in_take   = in_valid && !in_stall;
	assign ridx_wide = {3'b000, ridx_s1};

	sfr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sfr_core #(
		.PAYLOAD_DEPTH (PAYLOAD_DEPTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.cmd     (cmd_s1),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.res     (res),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata)
	);

	sfr_ram #(
		.WIDTH (8),
		.DEPTH (PAYLOAD_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (adv && (cmd_s1 == sfr_pkg::CMD_READ)),
		.raddr (ridx_wide[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_take) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				v_s2 <= 1'b1;
			end else if (!out_stall) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_s1  <= sfr_pkg::cmd_t'(command);
			byte_s1 <= rx_byte;
			ridx_s1 <= read_index;
		end
		if (adv) begin
			res_s2   <= res;
			rd_ok_s2 <= (cmd_s1 == sfr_pkg::CMD_READ) && (ridx_wide < 9'(PAYLOAD_DEPTH));
		end
	end

	assign out_valid     = v_s2;
	assign frame_ready   = res_s2.frame_ready;
	assign payload_count = res_s2.payload_count;
	assign byte_ignored  = res_s2.byte_ignored;
	assign read_byte     = rd_ok_s2 ? ram_rdata : 8'd0;

	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> v_s2)
		else $error("request advanced but no result was registered");

	a_no_bubble_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !v_s2) |-> !in_stall)
		else $error("input stalled while the result register was empty");

endmodule

FILE: hdl/sfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/sfr_cfg.sv
// Configuration register bank of the serial frame receiver.
module sfr_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0]     cfg_data,
	output sfr_pkg::cfg_t                      cfg
);

	sfr_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.head_byte        <= 8'd0;
			cfg_q.tail_byte        <= 8'd0;
			cfg_q.station_address  <= 8'd0;
			cfg_q.timeout_reload   <= sfr_pkg::TIMEOUT_RELOAD_RESET;
			cfg_q.max_frame_length <= sfr_pkg::MAX_FRAME_LENGTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sfr_pkg::REG_HEAD_BYTE: begin
					cfg_q.head_byte <= cfg_data[7:0];
				end
				sfr_pkg::REG_TAIL_BYTE: begin
					cfg_q.tail_byte <= cfg_data[7:0];
				end
				sfr_pkg::REG_STATION_ADDRESS: begin
					cfg_q.station_address <= cfg_data[7:0];
				end
				sfr_pkg::REG_TIMEOUT_RELOAD: begin
					cfg_q.timeout_reload <= cfg_data;
				end
				sfr_pkg::REG_MAX_FRAME_LENGTH: begin
					cfg_q.max_frame_length <= cfg_data[6:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: hdl/sfr_core.sv
// Frame parser: phase machine, checksum, timeout counter and held-frame flag.
module sfr_core #(
	parameter int PAYLOAD_DEPTH = 64,
	localparam int AW = $clog2(PAYLOAD_DEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  sfr_pkg::cmd_t      cmd,
	input  logic [7:0]         rx_byte,
	input  sfr_pkg::cfg_t      cfg,
	output sfr_pkg::result_t   res,
	output logic               wr_en,
	output logic [AW-1:0]      wr_addr,
	output logic [7:0]         wr_data
);

	typedef enum logic [2:0] {
		PH_HEAD = 3'd0,
		PH_ADDR = 3'd1,
		PH_LEN  = 3'd2,
		PH_DATA = 3'd3,
		PH_SUM  = 3'd4,
		PH_TAIL = 3'd5
	} phase_t;

	localparam logic [7:0] OVERHEAD = 8'(sfr_pkg::OVERHEAD_BYTES);

	phase_t      phase_q, phase_n, phase_eff;
	logic [6:0]  idx_q, idx_n, idx_eff, idx_inc;
	logic [7:0]  sum_q, sum_n, sum_eff;
	logic [7:0]  len_q, len_n, len_diff;
	logic        ready_q, ready_n;
	logic [15:0] tmo_q, tmo_n;
	logic        tmo_zero;
	logic        wr_req;
	logic        ignored;
	logic [8:0]  idx_wide;

	assign tmo_zero = (tmo_q == 16'd0);
	// An expired timeout restarts the hunt before the byte is looked at.
	assign phase_eff = tmo_zero ? PH_HEAD : phase_q;
	assign sum_eff   = tmo_zero ? 8'd0 : sum_q;
	assign idx_eff   = tmo_zero ? 7'd0 : idx_q;
	assign idx_inc   = idx_eff + 7'd1;
	assign idx_wide  = {2'b00, idx_eff};

	assign wr_en   = step && wr_req;
	assign wr_addr = idx_wide[AW-1:0];
	assign wr_data = rx_byte;

	always_comb begin
		phase_n = phase_q;
		idx_n   = idx_q;
		sum_n   = sum_q;
		len_n   = len_q;
		ready_n = ready_q;
		tmo_n   = tmo_q;
		wr_req  = 1'b0;
		ignored = 1'b0;
		case (cmd)
			sfr_pkg::CMD_BYTE: begin
				if (ready_q) begin
					ignored = 1'b1;
				end else begin
					phase_n = phase_eff;
					sum_n   = sum_eff;
					idx_n   = idx_eff;
					case (phase_eff)
						PH_HEAD: begin
							if (rx_byte == cfg.head_byte) begin
								phase_n = PH_ADDR;
								sum_n   = rx_byte;
								idx_n   = 7'd0;
								tmo_n   = cfg.timeout_reload;
							end
						end
						PH_ADDR: begin
							sum_n   = sum_eff + rx_byte;
							phase_n = (rx_byte == cfg.station_address) ? PH_LEN : PH_HEAD;
						end
						PH_LEN: begin
							len_n = rx_byte;
							if (rx_byte > {1'b0, cfg.max_frame_length}) begin
								phase_n = PH_HEAD;
							end else begin
								sum_n   = sum_eff + rx_byte;
								phase_n = (rx_byte <= OVERHEAD) ? PH_SUM : PH_DATA;
							end
						end
						PH_DATA: begin
							// Bytes past the end of the store still count in the checksum.
							wr_req = (idx_wide < 9'(PAYLOAD_DEPTH));
							sum_n  = sum_eff + rx_byte;
							idx_n  = idx_inc;
							if (({1'b0, idx_inc} + OVERHEAD) >= len_q) begin
								phase_n = PH_SUM;
								idx_n   = 7'd0;
							end
						end
						PH_SUM: begin
							phase_n = (sum_eff == rx_byte) ? PH_TAIL : PH_HEAD;
						end
						PH_TAIL: begin
							if (rx_byte == cfg.tail_byte) begin
								ready_n = 1'b1;
							end
							phase_n = PH_HEAD;
						end
						default: begin
							phase_n = PH_HEAD;
						end
					endcase
				end
			end
			sfr_pkg::CMD_TICK: begin
				if (!tmo_zero) begin
					tmo_n = tmo_q - 16'd1;
				end
			end
			sfr_pkg::CMD_RELEASE: begin
				ready_n = 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign len_diff = len_n - OVERHEAD;

	always_comb begin
		res.frame_ready   = ready_n;
		res.payload_count = (ready_n && (len_n > OVERHEAD)) ? len_diff[6:0] : 7'd0;
		res.byte_ignored  = ignored;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD;
			idx_q   <= 7'd0;
			sum_q   <= 8'd0;
			len_q   <= 8'd0;
			ready_q <= 1'b0;
			tmo_q   <= 16'd0;
		end else if (step) begin
			phase_q <= phase_n;
			idx_q   <= idx_n;
			sum_q   <= sum_n;
			len_q   <= len_n;
			ready_q <= ready_n;
			tmo_q   <= tmo_n;
		end
	end

	// A held frame only comes from a tail byte, after which the parser is back at the head.
	a_ready_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ready_q) |-> $past(step && (cmd == sfr_pkg::CMD_BYTE) && (phase_q == PH_TAIL)))
		else $error("frame_ready set without a tail byte");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> (phase_q == PH_HEAD))
		else $error("parser left the head phase while a frame is held");

	a_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(step && (cmd == sfr_pkg::CMD_TICK) && !tmo_zero) |=> (tmo_q == $past(tmo_q) - 16'd1))
		else $error("timeout counter did not count down on a tick");

	a_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ((cmd == sfr_pkg::CMD_BYTE) && !ready_q))
		else $error("payload store written outside a received byte");

endmodule
